@@ hdl/prff_pkg.sv @@
// ----------------------------------------------------------------------------
// prff_pkg
// Shared types and constants of the pollard rho factor finder.
// ----------------------------------------------------------------------------
package prff_pkg;

    localparam int DEF_WORD_BITS = 32;

    localparam int NUM_BITS   = 31;
    localparam int LIMIT_BITS = 24;
    localparam int STAT_BITS  = 2;
    localparam int IDX_BITS   = 2;

    localparam logic [NUM_BITS-1:0]   START_RST = NUM_BITS'(3);
    localparam logic [NUM_BITS-1:0]   CONST_RST = NUM_BITS'(1);
    localparam logic [LIMIT_BITS-1:0] LIMIT_RST = LIMIT_BITS'(1048575);

    localparam logic [IDX_BITS-1:0] REG_START_VALUE  = 2'd0;
    localparam logic [IDX_BITS-1:0] REG_ADD_CONSTANT = 2'd1;
    localparam logic [IDX_BITS-1:0] REG_ITER_LIMIT   = 2'd2;

    typedef enum logic [STAT_BITS-1:0] {
        STAT_FOUND   = 2'd0,
        STAT_TRIVIAL = 2'd1,
        STAT_LIMIT   = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RED_SEED,
        ST_RED_CONST,
        ST_ROUND,
        ST_MUL,
        ST_ADDC,
        ST_GCD_GO,
        ST_GCD_WAIT
    } t_state;

    // which walker step the current squaring belongs to
    typedef enum logic [1:0] {
        WALK_X,
        WALK_Y1,
        WALK_Y2
    } t_walk;

endpackage

@@ hdl/pollard_rho_factor_finder.sv @@
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder
// Pollard rho with Floyd cycle finding over one shared modular adder.
// ----------------------------------------------------------------------------
// One request is taken when start is high and busy is low; one result follows
// with a one-cycle o_result_valid strobe, which cannot be held off. Every
// modular operation runs through a single modular adder: a square is done by
// double-and-add over the WORD_BITS bits of the operand, and each round does
// three squarings, three constant adds and one binary gcd. Setup adds two
// reductions, of the seed and of the constant. An item takes setup plus its
// rounds; the round count is set by the smallest prime factor and capped
// by iteration_limit. A number below two answers in the cycle after the
// request. Register writes are taken only while idle with start low.
// WORD_BITS must be at least 31.
// ----------------------------------------------------------------------------
module pollard_rho_factor_finder #(
    parameter int WORD_BITS = prff_pkg::DEF_WORD_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [prff_pkg::NUM_BITS-1:0]   i_number_to_factor,
    output logic                            o_result_valid,
    output logic [prff_pkg::NUM_BITS-1:0]   o_factor_found,
    output logic [prff_pkg::STAT_BITS-1:0]  o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [prff_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [prff_pkg::NUM_BITS-1:0]   i_cfg_data
);

    localparam int BIT_W = $clog2(WORD_BITS);

    prff_pkg::t_state  r_state, n_state;
    prff_pkg::t_walk   r_sel, n_sel;
    prff_pkg::t_status r_status, n_status;

    logic                             r_strobe, n_strobe;
    logic [prff_pkg::NUM_BITS-1:0]    r_factor, n_factor;
    logic [prff_pkg::NUM_BITS-1:0]    r_start_value;
    logic [prff_pkg::NUM_BITS-1:0]    r_add_constant;
    logic [prff_pkg::LIMIT_BITS-1:0]  r_iter_limit;
    logic [prff_pkg::LIMIT_BITS-1:0]  r_round, n_round;

    logic [WORD_BITS-1:0] r_n, n_n;
    logic [WORD_BITS-1:0] r_x, n_x;
    logic [WORD_BITS-1:0] r_y, n_y;
    logic [WORD_BITS-1:0] r_c, n_c;
    logic [WORD_BITS-1:0] r_acc, n_acc;
    logic [WORD_BITS-1:0] r_mop, n_mop;
    logic [WORD_BITS-1:0] r_addend, n_addend;
    logic [BIT_W-1:0]     r_bit, n_bit;
    logic                 r_phase, n_phase;

    logic [WORD_BITS-1:0] w_b;
    logic [WORD_BITS-1:0] w_sum;
    logic                 w_mul_done;
    logic                 w_gcd_go;
    logic [WORD_BITS-1:0] w_diff;
    logic                 w_gcd_done;
    logic [WORD_BITS-1:0] w_gcd;
    logic                 w_small_n;
    logic                 w_accept;

    assign busy        = (r_state != prff_pkg::ST_IDLE);
    // no register write in the cycle a request is taken
    assign o_cfg_ready = !busy && !start;
    assign w_accept    = start && !busy;
    assign w_small_n   = (i_number_to_factor < prff_pkg::NUM_BITS'(2));

    // shared modular adder: doubling, bit add, or the constant add
    assign w_b = (r_state == prff_pkg::ST_ADDC) ? r_c : (r_phase ? r_addend : r_acc);

    prff_modadd #(
        .WORD_BITS (WORD_BITS)
    ) u_modadd (
        .i_a   (r_acc),
        .i_b   (w_b),
        .i_m   (r_n),
        .o_sum (w_sum)
    );

    assign w_mul_done = (r_phase || !r_mop[r_bit]) && (r_bit == '0);
    assign w_gcd_go   = (r_state == prff_pkg::ST_GCD_GO);
    assign w_diff     = (r_x >= r_y) ? (r_x - r_y) : (r_y - r_x);

    prff_gcd #(
        .WORD_BITS (WORD_BITS)
    ) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (w_gcd_go),
        .i_a     (w_diff),
        .i_b     (r_n),
        .o_done  (w_gcd_done),
        .o_gcd   (w_gcd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            prff_pkg::ST_IDLE: begin
                if (w_accept && !w_small_n) n_state = prff_pkg::ST_RED_SEED;
            end
            prff_pkg::ST_RED_SEED: begin
                if (w_mul_done) n_state = prff_pkg::ST_RED_CONST;
            end
            prff_pkg::ST_RED_CONST: begin
                if (w_mul_done) n_state = prff_pkg::ST_ROUND;
            end
            prff_pkg::ST_ROUND: begin
                if (r_round == r_iter_limit) n_state = prff_pkg::ST_IDLE;
                else n_state = prff_pkg::ST_MUL;
            end
            prff_pkg::ST_MUL: begin
                if (w_mul_done) n_state = prff_pkg::ST_ADDC;
            end
            prff_pkg::ST_ADDC: begin
                if (r_sel == prff_pkg::WALK_Y2) n_state = prff_pkg::ST_GCD_GO;
                else n_state = prff_pkg::ST_MUL;
            end
            prff_pkg::ST_GCD_GO: begin
                n_state = prff_pkg::ST_GCD_WAIT;
            end
            prff_pkg::ST_GCD_WAIT: begin
                if (w_gcd_done) begin
                    if (w_gcd == WORD_BITS'(1)) n_state = prff_pkg::ST_ROUND;
                    else n_state = prff_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prff_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and result
    always_comb begin
        n_sel    = r_sel;
        n_status = r_status;
        n_strobe = 1'b0;
        n_factor = r_factor;
        n_round  = r_round;
        n_n      = r_n;
        n_x      = r_x;
        n_y      = r_y;
        n_c      = r_c;
        n_acc    = r_acc;
        n_mop    = r_mop;
        n_addend = r_addend;
        n_bit    = r_bit;
        n_phase  = r_phase;

        // double-and-add step, shared by reductions and squarings
        if (r_state == prff_pkg::ST_RED_SEED || r_state == prff_pkg::ST_RED_CONST ||
            r_state == prff_pkg::ST_MUL) begin
            n_acc = w_sum;
            if (!r_phase && r_mop[r_bit]) begin
                n_phase = 1'b1;
            end else begin
                n_phase = 1'b0;
                n_bit   = r_bit - 1'b1;
            end
        end

        case (r_state)
            prff_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_n      = WORD_BITS'(i_number_to_factor);
                    n_round  = '0;
                    n_acc    = '0;
                    n_bit    = BIT_W'(WORD_BITS - 1);
                    n_phase  = 1'b0;
                    n_mop    = WORD_BITS'(r_start_value);
                    n_addend = WORD_BITS'(1);
                    if (w_small_n) begin
                        n_strobe = 1'b1;
                        n_factor = '0;
                        n_status = prff_pkg::STAT_TRIVIAL;
                    end
                end
            end
            prff_pkg::ST_RED_SEED: begin
                if (w_mul_done) begin
                    n_x      = w_sum;
                    n_y      = w_sum;
                    n_acc    = '0;
                    n_bit    = BIT_W'(WORD_BITS - 1);
                    n_phase  = 1'b0;
                    n_mop    = WORD_BITS'(r_add_constant);
                    n_addend = WORD_BITS'(1);
                end
            end
            prff_pkg::ST_RED_CONST: begin
                if (w_mul_done) n_c = w_sum;
            end
            prff_pkg::ST_ROUND: begin
                if (r_round == r_iter_limit) begin
                    n_strobe = 1'b1;
                    n_factor = '0;
                    n_status = prff_pkg::STAT_LIMIT;
                end else begin
                    n_round  = r_round + 1'b1;
                    n_sel    = prff_pkg::WALK_X;
                    n_acc    = '0;
                    n_bit    = BIT_W'(WORD_BITS - 1);
                    n_phase  = 1'b0;
                    n_mop    = r_x;
                    n_addend = r_x;
                end
            end
            prff_pkg::ST_MUL: begin
                n_sel = r_sel;
            end
            prff_pkg::ST_ADDC: begin
                n_acc   = '0;
                n_bit   = BIT_W'(WORD_BITS - 1);
                n_phase = 1'b0;
                case (r_sel)
                    prff_pkg::WALK_X: begin
                        n_x      = w_sum;
                        n_sel    = prff_pkg::WALK_Y1;
                        n_mop    = r_y;
                        n_addend = r_y;
                    end
                    prff_pkg::WALK_Y1: begin
                        // hare's first step feeds straight into its second
                        n_sel    = prff_pkg::WALK_Y2;
                        n_mop    = w_sum;
                        n_addend = w_sum;
                    end
                    default: begin
                        n_y = w_sum;
                    end
                endcase
            end
            prff_pkg::ST_GCD_GO: begin
                n_sel = r_sel;
            end
            prff_pkg::ST_GCD_WAIT: begin
                if (w_gcd_done && w_gcd != WORD_BITS'(1)) begin
                    n_strobe = 1'b1;
                    if (w_gcd == r_n) begin
                        n_factor = '0;
                        n_status = prff_pkg::STAT_TRIVIAL;
                    end else begin
                        n_factor = prff_pkg::NUM_BITS'(w_gcd);
                        n_status = prff_pkg::STAT_FOUND;
                    end
                end
            end
            default: begin
                n_sel = r_sel;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= prff_pkg::ST_IDLE;
            r_strobe       <= 1'b0;
            r_start_value  <= prff_pkg::START_RST;
            r_add_constant <= prff_pkg::CONST_RST;
            r_iter_limit   <= prff_pkg::LIMIT_RST;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    prff_pkg::REG_START_VALUE:  r_start_value  <= i_cfg_data;
                    prff_pkg::REG_ADD_CONSTANT: r_add_constant <= i_cfg_data;
                    prff_pkg::REG_ITER_LIMIT:
                        r_iter_limit <= i_cfg_data[prff_pkg::LIMIT_BITS-1:0];
                    default: begin
                        r_iter_limit <= r_iter_limit;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sel    <= n_sel;
        r_status <= n_status;
        r_factor <= n_factor;
        r_round  <= n_round;
        r_n      <= n_n;
        r_x      <= n_x;
        r_y      <= n_y;
        r_c      <= n_c;
        r_acc    <= n_acc;
        r_mop    <= n_mop;
        r_addend <= n_addend;
        r_bit    <= n_bit;
        r_phase  <= n_phase;
    end

    assign o_result_valid = r_strobe;
    assign o_factor_found = r_factor;
    assign o_status       = r_status;

`ifndef SYNTHESIS
    a_found_nontrivial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status == prff_pkg::STAT_FOUND) |->
        (o_factor_found != '0 && o_factor_found != prff_pkg::NUM_BITS'(1)))
        else $error("found factor is trivial");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != prff_pkg::STAT_FOUND) |-> (o_factor_found == '0))
        else $error("failure result carries a factor");

    a_result_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> !busy)
        else $error("result strobed while still searching");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_number_to_factor >= prff_pkg::NUM_BITS'(2)) |=> busy)
        else $error("request taken without starting a search");
`endif

endmodule

@@ hdl/prff_modadd.sv @@
// ----------------------------------------------------------------------------
// prff_modadd
// Modular adder: (a + b) mod m for a, b below m. Shared by every step of
// the reductions, the squarings and the constant add.
// ----------------------------------------------------------------------------
module prff_modadd #(
    parameter int WORD_BITS = prff_pkg::DEF_WORD_BITS
) (
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    input  logic [WORD_BITS-1:0] i_m,
    output logic [WORD_BITS-1:0] o_sum
);

    logic [WORD_BITS:0] w_raw;
    logic [WORD_BITS:0] w_red;

    assign w_raw = {1'b0, i_a} + {1'b0, i_b};
    assign w_red = w_raw - {1'b0, i_m};
    assign o_sum = (w_raw >= {1'b0, i_m}) ? w_red[WORD_BITS-1:0] : w_raw[WORD_BITS-1:0];

endmodule

@@ hdl/prff_gcd.sv @@
// ----------------------------------------------------------------------------
// prff_gcd
// Binary gcd unit: one shift or one subtract per cycle, b must be nonzero.
// ----------------------------------------------------------------------------
module prff_gcd #(
    parameter int WORD_BITS = prff_pkg::DEF_WORD_BITS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_go,
    input  logic [WORD_BITS-1:0] i_a,
    input  logic [WORD_BITS-1:0] i_b,
    output logic                 o_done,
    output logic [WORD_BITS-1:0] o_gcd
);

    localparam int K_BITS = $clog2(WORD_BITS + 1);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [WORD_BITS-1:0] r_a, n_a;
    logic [WORD_BITS-1:0] r_b, n_b;
    logic [K_BITS-1:0]    r_k, n_k;
    logic [WORD_BITS-1:0] r_gcd, n_gcd;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_a    = r_a;
        n_b    = r_b;
        n_k    = r_k;
        n_gcd  = r_gcd;
        if (i_go) begin
            n_a    = i_a;
            n_b    = i_b;
            n_k    = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            if (r_a == '0 || r_b == '0) begin
                // common power of two restored at the end
                n_gcd  = ((r_a == '0) ? r_b : r_a) << r_k;
                n_done = 1'b1;
                n_busy = 1'b0;
            end else if (!r_a[0] && !r_b[0]) begin
                n_a = r_a >> 1;
                n_b = r_b >> 1;
                n_k = r_k + 1'b1;
            end else if (!r_a[0]) begin
                n_a = r_a >> 1;
            end else if (!r_b[0]) begin
                n_b = r_b >> 1;
            end else if (r_a >= r_b) begin
                n_a = r_a - r_b;
            end else begin
                n_b = r_b - r_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_k   <= n_k;
        r_gcd <= n_gcd;
    end

    assign o_done = r_done;
    assign o_gcd  = r_gcd;

endmodule

@@ bench/pollard_rho_factor_finder_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder_checker
// Watches the request, result and register channels of the factor finder.
// It keeps its own copy of the three registers and runs the rho search in
// software for every accepted request. Each result strobe is compared, field
// by field, with the oldest expected result. Mismatches are counted and handed
// to the testbench top.
// ----------------------------------------------------------------------------
module pollard_rho_factor_finder_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic                            i_busy,
    input  logic [prff_pkg::NUM_BITS-1:0]   i_number,
    input  logic                            i_result_valid,
    input  logic [prff_pkg::NUM_BITS-1:0]   i_factor,
    input  logic [prff_pkg::STAT_BITS-1:0]  i_status,
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [prff_pkg::IDX_BITS-1:0]   i_cfg_index,
    input  logic [prff_pkg::NUM_BITS-1:0]   i_cfg_data,
    output int                              o_outstanding,
    output int                              o_mismatches
);

    typedef struct packed {
        logic [prff_pkg::NUM_BITS-1:0] number;
        logic [prff_pkg::NUM_BITS-1:0] factor;
        prff_pkg::t_status             status;
    } t_factor_expect;

    logic [prff_pkg::NUM_BITS-1:0]   seed_reg;
    logic [prff_pkg::NUM_BITS-1:0]   step_const;
    logic [prff_pkg::LIMIT_BITS-1:0] round_limit;
    t_factor_expect                  factor_results_q[$];
    int                              mismatch_count = 0;

    function automatic longint unsigned rho_step(input longint unsigned v,
                                                 input longint unsigned c,
                                                 input longint unsigned m);
        return ((v * v) % m + c) % m;
    endfunction

    // floyd walk: tortoise one step, hare two, gcd of the gap each round
    function automatic t_factor_expect rho_search(input logic [prff_pkg::NUM_BITS-1:0] n);
        t_factor_expect    res;
        longint unsigned   m;
        longint unsigned   x;
        longint unsigned   y;
        longint unsigned   c;
        longint unsigned   a;
        longint unsigned   b;
        longint unsigned   t;
        int unsigned       round;
        res.number = n;
        res.factor = '0;
        res.status = prff_pkg::STAT_TRIVIAL;
        if (n < 2) begin
            return res;
        end
        m = longint'(n);
        x = longint'(seed_reg) % m;
        y = x;
        c = longint'(step_const) % m;
        for (round = 0; round < round_limit; round++) begin
            x = rho_step(x, c, m);
            y = rho_step(rho_step(y, c, m), c, m);
            a = (x >= y) ? (x - y) : (y - x);
            b = m;
            while (b != 0) begin
                t = a % b;
                a = b;
                b = t;
            end
            if (a != 1) begin
                if (a != m) begin
                    res.factor = a[prff_pkg::NUM_BITS-1:0];
                    res.status = prff_pkg::STAT_FOUND;
                end
                return res;
            end
        end
        res.status = prff_pkg::STAT_LIMIT;
        return res;
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [prff_pkg::NUM_BITS-1:0] n,
                                   input logic [63:0] want, input logic [63:0] got);
        $display("[checker] %0t n=%0d %s: expected %0d, got %0d", $realtime, n, what,
                 want, got);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        t_factor_expect want;
        if (!i_rst_n) begin
            seed_reg    = prff_pkg::START_RST;
            step_const  = prff_pkg::CONST_RST;
            round_limit = prff_pkg::LIMIT_RST;
            factor_results_q.delete();
        end else begin
            // retire before taking a new request in the same cycle
            if (i_result_valid) begin
                if (factor_results_q.size() == 0) begin
                    report_mismatch("result with no request", '0, '0, i_factor);
                end else begin
                    want = factor_results_q.pop_front();
                    if (i_factor !== want.factor) begin
                        report_mismatch("factor_found", want.number, want.factor,
                                        i_factor);
                    end
                    if (i_status !== want.status) begin
                        report_mismatch("status", want.number, want.status, i_status);
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    prff_pkg::REG_START_VALUE: begin
                        seed_reg = i_cfg_data;
                    end
                    prff_pkg::REG_ADD_CONSTANT: begin
                        step_const = i_cfg_data;
                    end
                    prff_pkg::REG_ITER_LIMIT: begin
                        round_limit = i_cfg_data[prff_pkg::LIMIT_BITS-1:0];
                    end
                    default: begin
                    end
                endcase
            end
            if (i_start && !i_busy) begin
                factor_results_q.push_back(rho_search(i_number));
            end
        end
        o_outstanding <= factor_results_q.size();
        o_mismatches  <= mismatch_count;
    end

endmodule

@@ bench/pollard_rho_factor_finder_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pollard_rho_factor_finder_tb
// Stimulus and verdict for the pollard rho factor finder.
// A directed part covers tiny, prime and extreme numbers, a zero and a
// minimal round limit, extreme seeds and constants and the unused register
// index. Random phases then reprogram the registers and send numbers of
// mixed shape, with and without sender gaps. The checker does the comparing.
// ----------------------------------------------------------------------------
module pollard_rho_factor_finder_tb;

    localparam logic [prff_pkg::IDX_BITS-1:0] REG_UNUSED = 2'd3;
    localparam logic [prff_pkg::NUM_BITS-1:0] NUM_MAX    = 31'h7FFF_FFFF;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic [prff_pkg::NUM_BITS-1:0]   i_number_to_factor = '0;
    logic                            o_result_valid;
    logic [prff_pkg::NUM_BITS-1:0]   o_factor_found;
    logic [prff_pkg::STAT_BITS-1:0]  o_status;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [prff_pkg::IDX_BITS-1:0]   i_cfg_index = '0;
    logic [prff_pkg::NUM_BITS-1:0]   i_cfg_data = '0;
    int                              outstanding;
    int                              mismatches;
    int                              idle_pct = 0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    pollard_rho_factor_finder i_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_number_to_factor (i_number_to_factor),
        .o_result_valid     (o_result_valid),
        .o_factor_found     (o_factor_found),
        .o_status           (o_status),
        .i_cfg_valid        (i_cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data)
    );

    pollard_rho_factor_finder_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (start),
        .i_busy         (busy),
        .i_number       (i_number_to_factor),
        .i_result_valid (o_result_valid),
        .i_factor       (o_factor_found),
        .i_status       (o_status),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_outstanding  (outstanding),
        .o_mismatches   (mismatches)
    );

    // one request; start stays high afterwards until the next call or a drain
    task automatic send_number(input logic [prff_pkg::NUM_BITS-1:0] n);
        int gap;
        gap = 0;
        i_cfg_valid <= 1'b0;
        while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 40) begin
            gap++;
        end
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start              <= 1'b1;
        i_number_to_factor <= n;
        do @(posedge i_clk); while (busy);
    endtask

    // valid is left high; the next request lowers it
    task automatic write_reg(input logic [prff_pkg::IDX_BITS-1:0] idx,
                             input logic [prff_pkg::NUM_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic wait_idle();
        start       <= 1'b0;
        i_cfg_valid <= 1'b0;
        do @(posedge i_clk); while (outstanding != 0);
    endtask

    function automatic logic [prff_pkg::NUM_BITS-1:0] random_word();
        case ($urandom_range(7))
            0: return '0;
            1: return NUM_MAX;
            default: return prff_pkg::NUM_BITS'($urandom);
        endcase
    endfunction

    initial begin : stimulus
        logic [prff_pkg::NUM_BITS-1:0]   reset_set[10] =
            '{0, 1, 2, 3, 4, 15, 91, 97, 8051, 10403};
        logic [prff_pkg::NUM_BITS-1:0]   n;
        logic [prff_pkg::LIMIT_BITS-1:0] lim;
        int                              phase;
        int                              item;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: tiny numbers, small primes, quick composites
        foreach (reset_set[k]) begin
            send_number(reset_set[k]);
        end
        wait_idle();

        // unused index must not land anywhere; limit data with only high bits is zero
        write_reg(REG_UNUSED, NUM_MAX);
        write_reg(prff_pkg::REG_ITER_LIMIT, 31'h7F00_0000);
        send_number(8051);
        send_number(0);
        wait_idle();

        write_reg(prff_pkg::REG_ITER_LIMIT, 31'd1);
        send_number(NUM_MAX);
        send_number(31'h5555_5555);
        send_number(31'h2AAA_AAAA);
        wait_idle();

        write_reg(prff_pkg::REG_START_VALUE, NUM_MAX);
        write_reg(prff_pkg::REG_ADD_CONSTANT, NUM_MAX);
        write_reg(prff_pkg::REG_ITER_LIMIT, NUM_MAX);
        send_number(10403);
        send_number(4);
        send_number(221);
        wait_idle();

        // zero seed and constant: the walk sits at zero
        write_reg(prff_pkg::REG_START_VALUE, '0);
        write_reg(prff_pkg::REG_ADD_CONSTANT, '0);
        write_reg(prff_pkg::REG_ITER_LIMIT, 31'd5);
        send_number(91);
        send_number(NUM_MAX);

        for (phase = 0; phase < 5; phase++) begin
            wait_idle();
            idle_pct = (phase % 3 == 0) ? 0 : (phase % 3 == 1) ? 87 : 11;
            // one phase runs huge limits on small numbers, the rest short limits
            if (phase == 3) begin
                lim = prff_pkg::LIMIT_BITS'($urandom_range(1048576, 16777215));
            end else begin
                lim = prff_pkg::LIMIT_BITS'($urandom_range(0, 32));
            end
            write_reg(prff_pkg::REG_START_VALUE, random_word());
            write_reg(prff_pkg::REG_ADD_CONSTANT, random_word());
            write_reg(prff_pkg::REG_ITER_LIMIT, {7'($urandom), lim});
            for (item = 0; item < 20; item++) begin
                if (phase == 3) begin
                    n = prff_pkg::NUM_BITS'($urandom_range(0, 500));
                end else begin
                    case ($urandom_range(9))
                        0, 1, 2, 3: n = prff_pkg::NUM_BITS'($urandom);
                        4, 5, 6: n = prff_pkg::NUM_BITS'($urandom_range(2, 46340)
                                                         * $urandom_range(2, 46340));
                        7, 8: n = prff_pkg::NUM_BITS'($urandom_range(0, 3000));
                        default: n = random_word();
                    endcase
                end
                send_number(n);
            end
        end

        wait_idle();
        repeat (600) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[pollard_rho_factor_finder] OK");
        end else begin
            $display("[pollard_rho_factor_finder] ERROR");
        end
        $finish;
    end

    initial begin : watchdog
        #100_000_000;
        $display("[pollard_rho_factor_finder] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/prff_pkg.sv
hdl/prff_modadd.sv
hdl/prff_gcd.sv
hdl/pollard_rho_factor_finder.sv
bench/pollard_rho_factor_finder_checker.sv
bench/pollard_rho_factor_finder_tb.sv
